### rtl/core/cccs_pkg.sv
// Shared types, constants and the arctangent table for the circle setpoint block.
package cccs_pkg;

    localparam int ANG_TABLE_LEN = 24;
    localparam int CNT_W         = 5;
    localparam int ZW            = 34;
    localparam int DIV_NUM_W     = 30;

    localparam logic [29:0] INV_GAIN_Q30   = 30'd652032874;
    localparam logic [29:0] RAD_TO_BAM_Q16 = 30'd683565276;
    localparam logic [15:0] CARROT_MAX     = 16'd8192;
    localparam logic [15:0] CARROT_MIN     = 16'd2048;
    localparam logic [7:0]  RADIUS_MIN_Q8  = 8'd26;
    localparam logic [15:0] CARROT_RESET   = 16'd3072;
    localparam logic [15:0] QUARTER_TURN   = 16'd16384;

    localparam logic [0:0]  REG_CARROT_DIST = 1'b0;
    localparam logic        ACT_STEP        = 1'b0;

    typedef struct packed {
        logic start;
        logic rot;
    } t_cordic_ctl;

    function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/cccs_if.sv
// Valid/ready channel interfaces for input and result items.
interface cccs_in_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic                action;
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic signed [W-1:0] radius;
    modport source (output valid, action, pos_x, pos_y, center_x, center_y, radius,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, center_x, center_y, radius,
                    output ready);
endinterface

interface cccs_out_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] target_x;
    logic signed [W-1:0] target_y;
    logic signed [15:0]  bearing;
    logic signed [31:0]  turned_total;
    modport source (output valid, target_x, target_y, bearing, turned_total, input ready);
    modport sink   (input valid, target_x, target_y, bearing, turned_total, output ready);
endinterface

### rtl/core/cccs_cordic.sv
// Shared CORDIC unit: one micro-rotation per cycle, vectoring or rotation mode.
module cccs_cordic #(
    parameter int DW    = 44,
    parameter int ITERS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cccs_pkg::t_cordic_ctl        i_ctl,
    input  logic signed [DW-1:0]         i_x,
    input  logic signed [DW-1:0]         i_y,
    input  logic signed [cccs_pkg::ZW-1:0] i_z,
    output logic                         o_busy,
    output logic signed [DW-1:0]         o_x,
    output logic signed [DW-1:0]         o_y,
    output logic signed [cccs_pkg::ZW-1:0] o_z
);
    logic                           r_busy;
    logic                           r_rot;
    logic [cccs_pkg::CNT_W-1:0]     r_cnt;
    logic signed [DW-1:0]           r_x, r_y, n_x, n_y, xs, ys;
    logic signed [cccs_pkg::ZW-1:0] r_z, n_z, ang;
    logic                           sigma;

    always_comb begin
        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;
        ang = signed'({2'b00, cccs_pkg::atan_entry(r_cnt)});
        // rotation drives z toward zero, vectoring drives y toward zero
        sigma = r_rot ? !r_z[cccs_pkg::ZW-1] : (r_y[DW-1] || (r_y == '0));
        if (sigma) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == cccs_pkg::CNT_W'(ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_rot <= i_ctl.rot;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

### rtl/core/cccs_div.sv
// Restoring divider, one quotient bit per cycle, for the carrot angle.
module cccs_div #(
    parameter int W = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [cccs_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [W-1:0]                        i_den,
    output logic                                o_busy,
    output logic [cccs_pkg::DIV_NUM_W-1:0]      o_quo
);
    localparam int NW = cccs_pkg::DIV_NUM_W;

    logic                         r_busy;
    logic [cccs_pkg::CNT_W-1:0]   r_cnt;
    logic [W:0]                   r_rem, trial;
    logic [W-1:0]                 r_den;
    logic [NW-1:0]                r_num, r_quo;
    logic                         fits;

    always_comb begin
        trial = {r_rem[W-1:0], r_num[NW-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == cccs_pkg::CNT_W'(NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

### rtl/core/circle_carrot_setpoint.sv
// Top level: carrot-chasing circle setpoint with sequencer, CORDIC and divider.
// A full circle step runs through setup, the bearing pass, the divide, the target pass
// and finish before its result is valid. The shared CORDIC unit runs once in vectoring
// mode for the bearing and once in rotation mode for the target, and the
// one-bit-per-cycle divider produces the carrot angle in between. A radius
// below 0.1 m but not zero ends after the bearing pass, and a zero radius skips the
// CORDIC entirely. A stage-init item clears the turned total. The input is not ready
// while a step is in progress and becomes ready in the cycle its result turns valid.
// A finished result waits in the output register and a new item can be taken
// meanwhile; a step that finishes while that register is still full holds in its
// last state until the register is taken.
// carrot_dist is decoded from paddr[2] alone, so it answers at APB addresses 0 to 3.
module circle_carrot_setpoint #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cccs_in_if.sink     i_in,
    cccs_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 20;
    localparam int ZW    = cccs_pkg::ZW;
    localparam int ITERS = (CORDIC_STEPS < cccs_pkg::ANG_TABLE_LEN) ?
                           CORDIC_STEPS : cccs_pkg::ANG_TABLE_LEN;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_VEC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ROT  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]  r_state;
    logic [15:0] r_carrot;
    logic [15:0] r_last;
    logic signed [31:0] r_sum;

    logic signed [W-1:0] r_px, r_py, r_cx, r_cy, r_r;
    logic                r_zero_vec, r_flip;
    logic [29:0]         r_num;
    logic signed [DW-1:0] r_x0;
    logic signed [W-1:0] r_tx, r_ty;

    logic                r_ovalid;
    logic signed [W-1:0] r_otx, r_oty;
    logic [15:0]         r_obear;
    logic signed [31:0]  r_osum;

    // config port
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == cccs_pkg::REG_CARROT_DIST);
    assign prdata = (paddr[2] == cccs_pkg::REG_CARROT_DIST) ? {16'b0, r_carrot} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrot <= cccs_pkg::CARROT_RESET;
        end else if (cfg_we) begin
            r_carrot <= pwdata[15:0];
        end
    end

    // shared units
    cccs_pkg::t_cordic_ctl cctl;
    logic signed [DW-1:0]  c_xi, c_yi, c_xo, c_yo;
    logic signed [ZW-1:0]  c_zi, c_zo;
    logic                  c_busy, d_start, d_busy;
    logic [29:0]           d_quo;

    cccs_cordic #(.DW(DW), .ITERS(ITERS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(cctl),
        .i_x(c_xi), .i_y(c_yi), .i_z(c_zi),
        .o_busy(c_busy), .o_x(c_xo), .o_y(c_yo), .o_z(c_zo)
    );

    logic [W-1:0] ar;
    assign ar = r_r[W-1] ? W'(-r_r) : W'(r_r);

    cccs_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(r_num), .i_den(ar), .o_busy(d_busy), .o_quo(d_quo)
    );

    // datapath helpers
    logic signed [W:0]    dx, dy;
    logic signed [DW-1:0] vx, vy;
    logic [W+29:0]        prod_x0;
    logic [45:0]          prod_num;
    logic [31:0]          zr;
    logic [15:0]          bear, dlt, ca, ang;
    logic signed [32:0]   s_sum;
    logic signed [31:0]   sum_sat;
    logic signed [ZW-1:0] t0;
    logic                 flip;
    logic signed [DW-1:0] rxr, ryr;
    logic signed [W+3:0]  oxr, oyr;
    logic signed [W+4:0]  sx, sy;
    logic signed [W-1:0]  tx_sat, ty_sat;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+4:0] v);
        logic signed [W+4:0] hi, lo;
        hi = (W+5)'({1'b0, {(W-1){1'b1}}});
        lo = -hi - 1'b1;
        if (v > hi) return W'(hi);
        if (v < lo) return W'(lo);
        return W'(v);
    endfunction

    always_comb begin
        dx = {r_px[W-1], r_px} - {r_cx[W-1], r_cx};
        dy = {r_py[W-1], r_py} - {r_cy[W-1], r_cy};
        vx = {{(DW-W-17){dx[W]}}, dx, 16'b0};
        vy = {{(DW-W-17){dy[W]}}, dy, 16'b0};
        prod_x0  = ar * cccs_pkg::INV_GAIN_Q30;
        prod_num = r_carrot * cccs_pkg::RAD_TO_BAM_Q16;

        zr   = c_zo[31:0] + 32'h0000_8000;
        bear = r_zero_vec ? 16'h0 : zr[31:16];
        dlt  = bear - r_last;
        s_sum = 33'(r_sum) + 33'(signed'(dlt));
        if (s_sum > 33'sd2147483647) begin
            sum_sat = 32'h7FFF_FFFF;
        end else if (s_sum < -33'sd2147483648) begin
            sum_sat = 32'h8000_0000;
        end else begin
            sum_sat = s_sum[31:0];
        end

        if (d_quo > 30'(cccs_pkg::CARROT_MAX)) begin
            ca = cccs_pkg::CARROT_MAX;
        end else if (d_quo < 30'(cccs_pkg::CARROT_MIN)) begin
            ca = cccs_pkg::CARROT_MIN;
        end else begin
            ca = d_quo[15:0];
        end
        ang = r_r[W-1] ? (r_last + ca) : (r_last - ca);
        // fold into the right half plane, negate the result later
        t0   = {{(ZW-32){ang[15]}}, ang, 16'b0};
        flip = 1'b0;
        if (signed'(ang) > signed'(cccs_pkg::QUARTER_TURN)) begin
            t0   = t0 - (ZW'(1) <<< 31);
            flip = 1'b1;
        end else if (signed'(ang) < -signed'(cccs_pkg::QUARTER_TURN)) begin
            t0   = t0 + (ZW'(1) <<< 31);
            flip = 1'b1;
        end

        rxr = (c_xo + DW'(32768)) >>> 16;
        ryr = (c_yo + DW'(32768)) >>> 16;
        oxr = r_flip ? -rxr[W+3:0] : rxr[W+3:0];
        oyr = r_flip ? -ryr[W+3:0] : ryr[W+3:0];
        sx  = (W+5)'(r_cx) + (W+5)'(oxr);
        sy  = (W+5)'(r_cy) + (W+5)'(oyr);
        tx_sat = sat_w(sx);
        ty_sat = sat_w(sy);
    end

    always_comb begin
        cctl    = '0;
        c_xi    = vx;
        c_yi    = vy;
        c_zi    = '0;
        d_start = 1'b0;
        if (r_state == S_PREP) begin
            cctl.start = (r_r != '0);
            if (dx[W]) begin
                c_xi = -vx;
                c_yi = -vy;
                c_zi = ZW'(34'h0_8000_0000);
            end
        end else if (r_state == S_VEC) begin
            d_start = !c_busy && (ar >= W'(cccs_pkg::RADIUS_MIN_Q8));
        end else if (r_state == S_DIV) begin
            cctl.start = !d_busy;
            cctl.rot   = 1'b1;
            c_xi       = r_x0;
            c_yi       = '0;
            c_zi       = t0;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.action == cccs_pkg::ACT_STEP) begin
                            r_state <= S_PREP;
                        end else begin
                            r_sum <= '0;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= (r_r == '0) ? S_FIN : S_VEC;
                end
                S_VEC: begin
                    if (!c_busy) begin
                        r_last  <= bear;
                        r_sum   <= sum_sat;
                        r_state <= (ar >= W'(cccs_pkg::RADIUS_MIN_Q8)) ? S_DIV : S_FIN;
                    end
                end
                S_DIV: begin
                    if (!d_busy) begin
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!c_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_px <= i_in.pos_x;
            r_py <= i_in.pos_y;
            r_cx <= i_in.center_x;
            r_cy <= i_in.center_y;
            r_r  <= i_in.radius;
        end
        if (r_state == S_PREP) begin
            r_zero_vec <= (dx == '0) && (dy == '0);
            r_x0       <= DW'(prod_x0[W+29:14]);
            r_num      <= prod_num[45:16];
            r_tx       <= r_cx;
            r_ty       <= r_cy;
        end
        if (r_state == S_DIV) begin
            r_flip <= flip;
        end
        if (r_state == S_ROT && !c_busy) begin
            r_tx <= tx_sat;
            r_ty <= ty_sat;
        end
        if (r_state == S_FIN && (!r_ovalid || o_out.ready)) begin
            r_otx   <= r_tx;
            r_oty   <= r_ty;
            r_obear <= r_last;
            r_osum  <= r_sum;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.target_x     = r_otx;
    assign o_out.target_y     = r_oty;
    assign o_out.bearing      = r_obear;
    assign o_out.turned_total = r_osum;
endmodule

### rtl/core/cccs_checker.sv
// Port-level checker for the circle setpoint block, bound to the top level.
module cccs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    a_busy_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_action == cccs_pkg::ACT_STEP) |=> !in_ready)
        else $error("input still ready after a circle step was taken");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after an item");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr == 3'd0) |=>
        (paddr != 3'd0) || (prdata == {16'b0, $past(pwdata[15:0])}))
        else $error("carrot_dist readback mismatch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");
endmodule

bind circle_carrot_setpoint cccs_checker u_cccs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_action (i_in.action),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

### tb/sv/circle_carrot_setpoint_test.sv
// Self-checking testbench for the circle carrot setpoint block: random and directed steps.
`timescale 1ns / 1ps
module circle_carrot_setpoint_test;

    localparam int CW = 24;
    localparam int STEPS = 16;
    localparam int TAB_LEN = 24;
    localparam longint COORD_HI = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_LO = -(64'sd1 <<< (CW - 1));

    typedef struct packed {
        logic                 action;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] radius;
    } t_step;

    typedef struct packed {
        logic signed [CW-1:0] target_x;
        logic signed [CW-1:0] target_y;
        logic signed [15:0]   bearing;
        logic signed [31:0]   turned_total;
    } t_setpoint;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cccs_in_if  #(.W(CW)) in_ch ();
    cccs_out_if #(.W(CW)) out_ch ();

    circle_carrot_setpoint #(.CORDIC_STEPS(STEPS), .COORD_WIDTH(CW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0]        carrot_dist_q = cccs_pkg::CARROT_RESET;
    logic [15:0]        prev_bearing = '0;
    logic signed [31:0] turn_sum = '0;

    t_step     pending_steps[$];
    t_setpoint expected_setpoints[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    bit        hold_off = 1'b0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] bearing_of(longint dx, longint dy);
        logic [31:0] z;
        longint x, y, nx, ny;
        z = '0;
        if (dx == 0 && dy == 0) return 16'd0;
        x = dx * 65536;
        y = dy * 65536;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z = z + cccs_pkg::atan_entry(i[cccs_pkg::CNT_W-1:0]);
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z = z - cccs_pkg::atan_entry(i[cccs_pkg::CNT_W-1:0]);
            end
            x = nx;
            y = ny;
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    task automatic rotate_radius(input longint mag, input logic [15:0] a,
                                 output longint ox, output longint oy);
        longint t, x, y, nx, ny;
        bit flip;
        t = longint'($signed(a)) * 65536;
        y = 0;
        flip = 1'b0;
        if (t > (64'sd1 <<< 30)) begin
            t -= 64'sd1 <<< 31;
            flip = 1'b1;
        end else if (t < -(64'sd1 <<< 30)) begin
            t += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        x = (mag * longint'(cccs_pkg::INV_GAIN_Q30)) >>> 14;
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (t >= 0) begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                t -= longint'(cccs_pkg::atan_entry(i[cccs_pkg::CNT_W-1:0]));
            end else begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                t += longint'(cccs_pkg::atan_entry(i[cccs_pkg::CNT_W-1:0]));
            end
            x = nx;
            y = ny;
        end
        x = shr_floor(x + 32768, 16);
        y = shr_floor(y + 32768, 16);
        ox = flip ? -x : x;
        oy = flip ? -y : y;
    endtask

    function automatic longint clamp_coord(longint v);
        return v > COORD_HI ? COORD_HI : (v < COORD_LO ? COORD_LO : v);
    endfunction

    // advances the guidance state for one accepted item, queues a setpoint for a step item
    task automatic predict_setpoint(input t_step s);
        longint px, py, cx, cy, r, ar, tx, ty, d, sum, ca, ox, oy;
        logic [15:0] b, ang;
        t_setpoint e;
        if (s.action != cccs_pkg::ACT_STEP) begin
            turn_sum = '0;
            return;
        end
        px = s.pos_x; py = s.pos_y; cx = s.center_x; cy = s.center_y; r = s.radius;
        ar = r < 0 ? -r : r;
        tx = cx;
        ty = cy;
        if (r != 0) begin
            b = bearing_of(px - cx, py - cy);
            d = longint'($signed(16'(b - prev_bearing)));
            sum = longint'(turn_sum) + d;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            turn_sum = sum[31:0];
            prev_bearing = b;
            if (ar >= longint'(cccs_pkg::RADIUS_MIN_Q8)) begin
                ca = longint'(carrot_dist_q) * longint'(cccs_pkg::RAD_TO_BAM_Q16) /
                     (ar * 65536);
                if (ca > longint'(cccs_pkg::CARROT_MAX)) ca = longint'(cccs_pkg::CARROT_MAX);
                if (ca < longint'(cccs_pkg::CARROT_MIN)) ca = longint'(cccs_pkg::CARROT_MIN);
                ang = r > 0 ? 16'(b - ca[15:0]) : 16'(b + ca[15:0]);
                rotate_radius(ar, ang, ox, oy);
                tx = clamp_coord(cx + ox);
                ty = clamp_coord(cy + oy);
            end
        end
        e.target_x = tx[CW-1:0];
        e.target_y = ty[CW-1:0];
        e.bearing = prev_bearing;
        e.turned_total = turn_sum;
        expected_setpoints.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // driver: the item on the bus stays at the head of the queue until taken
    int in_wait = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_setpoint(pending_steps.pop_front());
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_wait > 0 || pending_steps.size() == 0) begin
                    in_ch.valid <= 1'b0;
                    if (in_wait > 0) in_wait <= in_wait - 1;
                end else begin
                    t_step s;
                    s = pending_steps[0];
                    in_ch.valid    <= 1'b1;
                    in_ch.action   <= s.action;
                    in_ch.pos_x    <= s.pos_x;
                    in_ch.pos_y    <= s.pos_y;
                    in_ch.center_x <= s.center_x;
                    in_ch.center_y <= s.center_y;
                    in_ch.radius   <= s.radius;
                    in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // monitor
    int out_wait = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_setpoints.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    t_setpoint e;
                    e = expected_setpoints.pop_front();
                    if (out_ch.target_x !== e.target_x)
                        report_mismatch("target_x", out_ch.target_x, e.target_x);
                    if (out_ch.target_y !== e.target_y)
                        report_mismatch("target_y", out_ch.target_y, e.target_y);
                    if (out_ch.bearing !== e.bearing)
                        report_mismatch("bearing", out_ch.bearing, e.bearing);
                    if (out_ch.turned_total !== e.turned_total)
                        report_mismatch("turned_total", out_ch.turned_total, e.turned_total);
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_ch.ready <= 1'b0;
                out_wait <= out_wait - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 2_000_000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        carrot_dist_q = data[15:0];
    endtask

    task automatic wait_drained();
        while (pending_steps.size() > 0 || in_ch.valid || expected_setpoints.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return COORD_HI[CW-1:0];
            1: return COORD_LO[CW-1:0];
            2: return CW'($signed($urandom_range(0, 4000)) - 2000);
            default: return CW'($urandom());
        endcase
    endfunction

    function automatic t_step rand_step();
        t_step s;
        s.action = ($urandom_range(0, 19) == 0);
        s.center_x = ($urandom_range(0, 3) == 0) ? rand_coord() :
                     CW'(int'($urandom_range(0, 65535)) - 32768);
        s.center_y = ($urandom_range(0, 3) == 0) ? rand_coord() :
                     CW'(int'($urandom_range(0, 65535)) - 32768);
        case ($urandom_range(0, 7))
            0: s.radius = '0;
            1: s.radius = CW'(int'($urandom_range(0, 60)) - 30);
            2: s.radius = rand_coord();
            default: s.radius = CW'(($urandom_range(0, 1) ? 1 : -1) *
                                    int'($urandom_range(26, 40000)));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            s.pos_x = rand_coord();
            s.pos_y = rand_coord();
        end else begin
            s.pos_x = CW'(s.center_x + int'($urandom_range(0, 20000)) - 10000);
            s.pos_y = CW'(s.center_y + int'($urandom_range(0, 20000)) - 10000);
        end
        return s;
    endfunction

    function automatic t_step mk(logic a, longint px, longint py, longint cx, longint cy,
                                 longint r);
        t_step s;
        s.action = a; s.pos_x = CW'(px); s.pos_y = CW'(py);
        s.center_x = CW'(cx); s.center_y = CW'(cy); s.radius = CW'(r);
        return s;
    endfunction

    initial begin
        logic [31:0] carrot_settings[5];
        in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.pos_x = '0; in_ch.pos_y = '0;
        in_ch.center_x = '0; in_ch.center_y = '0; in_ch.radius = '0;
        out_ch.ready = 1'b0;
        carrot_settings = '{0, 65535, 1, 3072, 40000};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero radius, tiny radius, position at centre, extremes, stage init
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 100, 200, 5, 6, 0));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 1000, 0, 0, 0, 2560));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 0, 1000, 0, 0, -2560));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1000, 0, 0, 0, 25));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 0, -1000, 0, 0, -1));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 50, 50, 50, 50, 1000));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1000, 1, 0, 0, 26));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1000, -1, 0, 0, -26));
        pending_steps.push_back(mk(1'b1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, COORD_HI, COORD_HI, COORD_LO,
                                   COORD_LO, COORD_HI));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, COORD_LO, COORD_LO, COORD_HI,
                                   COORD_HI, COORD_LO));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, 0, 0, COORD_HI, COORD_HI, COORD_HI));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1, -1, COORD_LO, COORD_LO, COORD_LO));
        pending_steps.push_back(mk(1'b1, -1, -1, -1, -1, -1));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1, 0, 0, 0, 100));
        pending_steps.push_back(mk(cccs_pkg::ACT_STEP, -1, 0, 0, 0, -100));
        // spin the same way many times to drive the turned total up
        for (int k = 0; k < 8; k++)
            pending_steps.push_back(mk(cccs_pkg::ACT_STEP,
                                       (k % 4 == 0) ? 1000 : (k % 4 == 2) ? -1000 : 0,
                                       (k % 4 == 1) ? 1000 : (k % 4 == 3) ? -1000 : 0,
                                       0, 0, 500));
        wait_drained();

        foreach (carrot_settings[c]) begin
            apb_write(3'd0, carrot_settings[c]);
            for (int n = 0; n < 360; n++) pending_steps.push_back(rand_step());
            if (c == 1) begin
                // receiver holds off while the sender keeps offering
                while (pending_steps.size() > 350) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
